>>> design/sapq_pkg.sv
package sapq_pkg;

	localparam int CAPACITY    = 128;
	localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int OCC_W       = $clog2(CAPACITY + 1);
	localparam int VALUE_W     = 32;
	localparam int COUNT_W     = 8;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 48;

	localparam logic [VALUE_W-1:0] EMPTY_FRONT = '1;

	typedef enum logic {
		FUNC_INSERT = 1'b0,
		FUNC_REMOVE = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic load;
		logic wr_new;
		logic wr_shift;
		logic rd_prev;
		logic rd_head;
		logic load_result;
	} sapq_cmd_t;

	typedef struct packed {
		logic in_insert;
		logic full;
		logic empty;
		logic pos_zero;
		logic less;
		logic out_busy;
	} sapq_sts_t;

	// circular address: base + off, wrapped at CAPACITY
	function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
			input logic [ADDR_W-1:0] off);
		logic [ADDR_W:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (ADDR_W+1)'(CAPACITY)) begin
			sum = sum - (ADDR_W+1)'(CAPACITY);
		end
		return sum[ADDR_W-1:0];
	endfunction

endpackage

>>> design/sapq_ram.sv
module sapq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/sapq_ctrl.sv
module sapq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  sapq_pkg::sapq_sts_t sts,
	output sapq_pkg::sapq_cmd_t cmd
);

	import sapq_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_READ  = 6'b000010,
		S_CMP   = 6'b000100,
		S_FRONT = 6'b001000,
		S_FWAIT = 6'b010000,
		S_SPARE = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = (sts.in_insert && !sts.full) ? S_READ : S_FRONT;
				end
			end
			S_READ: begin
				// walk from the tail towards the front
				if (sts.pos_zero) begin
					cmd.wr_new = 1'b1;
					state_d    = S_FRONT;
				end else begin
					cmd.rd_prev = 1'b1;
					state_d     = S_CMP;
				end
			end
			S_CMP: begin
				if (sts.less) begin
					cmd.wr_shift = 1'b1;
					state_d      = S_READ;
				end else begin
					cmd.wr_new = 1'b1;
					state_d    = S_FRONT;
				end
			end
			S_FRONT: begin
				cmd.rd_head = 1'b1;
				state_d     = S_FWAIT;
			end
			S_FWAIT: begin
				// hold until the output register is free
				if (!sts.out_busy) begin
					cmd.load_result = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> design/sapq_datapath.sv
module sapq_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [sapq_pkg::IN_TDATA_W-1:0]      s_tdata,
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [sapq_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic [1:0]                           m_tuser,
	input  sapq_pkg::sapq_cmd_t                  cmd,
	output sapq_pkg::sapq_sts_t                  sts
);

	import sapq_pkg::*;

	logic signed [VALUE_W-1:0] item_q;
	status_t                   status_q;
	logic [OCC_W-1:0]          occ_q;
	logic [ADDR_W-1:0]         head_q;
	logic [ADDR_W-1:0]         pos_q;

	logic [VALUE_W-1:0] front_q;
	status_t            res_status_q;
	logic               res_empty_q;
	logic [COUNT_W-1:0] res_count_q;
	logic               out_valid_q;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [VALUE_W-1:0]  ram_wdata;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [VALUE_W-1:0]  ram_rdata;

	logic full, empty;

	assign full  = (occ_q == OCC_W'(CAPACITY));
	assign empty = (occ_q == '0);

	assign sts.in_insert = (func_t'(s_tuser) == FUNC_INSERT);
	assign sts.full      = full;
	assign sts.empty     = empty;
	assign sts.pos_zero  = (pos_q == '0);
	assign sts.less      = ($signed(ram_rdata) < item_q);
	assign sts.out_busy  = out_valid_q && !m_tready;

	assign ram_we    = cmd.wr_new | cmd.wr_shift;
	assign ram_waddr = wrap_add(head_q, pos_q);
	assign ram_wdata = cmd.wr_shift ? ram_rdata : item_q;
	assign ram_re    = cmd.rd_prev | cmd.rd_head;
	assign ram_raddr = cmd.rd_head ? head_q : wrap_add(head_q, pos_q - ADDR_W'(1));

	sapq_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			head_q <= '0;
		end else if (cmd.load) begin
			// a remove only advances the head
			if (!sts.in_insert && !empty) begin
				head_q <= wrap_add(head_q, ADDR_W'(1));
				occ_q  <= occ_q - OCC_W'(1);
			end
		end else if (cmd.wr_new) begin
			occ_q <= occ_q + OCC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= $signed(s_tdata[VALUE_W-1:0]);
			pos_q  <= occ_q[ADDR_W-1:0];
			if (sts.in_insert && full) begin
				status_q <= ST_OVERFLOW;
			end else if (!sts.in_insert && empty) begin
				status_q <= ST_UNDERFLOW;
			end else begin
				status_q <= ST_OK;
			end
		end else if (cmd.wr_shift) begin
			pos_q <= pos_q - ADDR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			front_q      <= empty ? EMPTY_FRONT : ram_rdata;
			res_status_q <= status_q;
			res_empty_q  <= empty;
			res_count_q  <= COUNT_W'(occ_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_status_q;
	assign m_tdata  = {
		(OUT_TDATA_W - VALUE_W - 1 - COUNT_W)'(0),
		res_count_q,
		res_empty_q,
		front_q
	};

endmodule

>>> design/sorted_array_priority_queue.sv
// Priority queue of signed 32-bit values, kept in descending order.
// Input stream: s_tuser selects the operation (0 insert, 1 remove front),
// s_tdata carries the value to insert (ignored on remove).
// Output stream: one result per request. m_tuser is the status (0 ok,
// 1 overflow, 2 underflow); m_tdata holds the front value after the
// operation (all ones when empty), the empty flag and the entry count.
// Entries sit in a circular buffer in a single RAM (one write, one read
// port, registered read), so a remove only advances the head pointer.
// After acceptance, every request reads the head entry and then loads the
// result; an insert that is not rejected first moves k stored entries back
// and writes its value behind a larger or equal entry, or at the front when
// it gets there (k up to 127). Each moved entry costs one RAM read and
// one RAM write, which sets the insert time. One request is in work at a
// time; the next is accepted once the previous result is in the output
// register. Reset empties the queue and clears the output valid at once;
// RAM contents are not cleared. While the receiver stalls, the result holds
// on m_tdata and m_tuser, one further request may be worked on, and its
// result waits until the output register is free.
module sorted_array_priority_queue (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [sapq_pkg::IN_TDATA_W-1:0]      s_tdata,   // [31:0] value
	input  logic                                 s_tuser,   // [0] func
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [sapq_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [31:0] front_value,
	                                                        // [32] is_empty,
	                                                        // [40:33] count
	output logic [1:0]                           m_tuser    // [1:0] status
);

	import sapq_pkg::*;

	sapq_cmd_t cmd;
	sapq_sts_t sts;

	sapq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sapq_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

>>> design/sapq_checker.sv
module sapq_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [sapq_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [1:0]                       m_tuser
);

	import sapq_pkg::*;

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[32] == (m_tdata[40:33] == '0)))
		else $error("empty flag disagrees with count");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[32] |-> (m_tdata[31:0] == EMPTY_FRONT))
		else $error("empty queue shows a front value");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_UNDERFLOW) |-> m_tdata[32])
		else $error("underflow on a non-empty queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_OVERFLOW) |-> (m_tdata[40:33] == COUNT_W'(CAPACITY)))
		else $error("overflow on a queue that is not full");

endmodule

bind sorted_array_priority_queue sapq_checker u_sapq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
